FILE: hw/rtl/pbc_pkg.sv
// Shared constants for the pileup base counter: character codes, count lane
// indices and the fixed width of the result ports. Used by every RTL file.
package pbc_pkg;

  localparam int OUT_BITS = 16;

  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [3:0] RADIX    = 4'd10;

  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_C = 2'd1;
  localparam logic [1:0] SLOT_G = 2'd2;
  localparam logic [1:0] SLOT_T = 2'd3;

endpackage

FILE: hw/rtl/pileup_base_count_parser.sv
// Pileup base counter: one read-base character per cycle, one result per string.
// Path: a last character is accepted into the input register, and from there
// it loads the result register.
// Throughput: one character per cycle; a last character waits in the input
// register only while the previous result is still unaccepted.
// Reset (rst, synchronous, active high) empties both registers and clears counts.
module pileup_base_count_parser
  import pbc_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          symbol,
  input  logic [7:0]          ref_base,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] count_a,
  output logic [OUT_BITS-1:0] count_c,
  output logic [OUT_BITS-1:0] count_g,
  output logic [OUT_BITS-1:0] count_t,
  output logic [OUT_BITS-1:0] coverage,
  output logic                overflow
);

  // Input register. A transaction lands here first, so the parse logic sees
  // registered characters.
  logic       s1_valid;
  logic [7:0] s1_sym;
  logic [7:0] s1_rbase;
  logic       s1_last;

  logic                       advance;
  logic                       res_can_load;
  logic [3:0][COUNT_BITS-1:0] done_counts;
  logic                       done_sat;

  // A character that ends a string needs room in the result register; every
  // other character moves on unconditionally, even while a result waits.
  assign advance  = s1_valid && (!s1_last || res_can_load);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_sym   <= symbol;
      s1_rbase <= ref_base;
      s1_last  <= last;
    end
  end

  // Parse state machine and saturating counters. On the last character the
  // updated counts are handed to the result register and the state clears.
  pbc_parse #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .sym         (s1_sym),
    .rbase       (s1_rbase),
    .last        (s1_last),
    .done_counts (done_counts),
    .done_sat    (done_sat)
  );

  // Result register; coverage and the overflow flag are formed from it.
  pbc_result #(
    .COUNT_BITS (COUNT_BITS)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && s1_last),
    .counts_in (done_counts),
    .sat_in    (done_sat),
    .can_load  (res_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .count_a   (count_a),
    .count_c   (count_c),
    .count_g   (count_g),
    .count_t   (count_t),
    .coverage  (coverage),
    .overflow  (overflow)
  );

endmodule

FILE: hw/rtl/pbc_parse.sv
// Parser state and base counters for the pileup base counter.
// Depends on pbc_pkg for character codes and lane indices.
module pbc_parse
  import pbc_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [7:0]                 sym,
  input  logic [7:0]                 rbase,
  input  logic                       last,
  output logic [3:0][COUNT_BITS-1:0] done_counts,
  output logic                       done_sat
);

  typedef enum logic [1:0] {MODE_NORMAL, MODE_SKIP, MODE_SIGN, MODE_DIGITS} mode_t;

  mode_t                       mode, mode_next;
  logic [LENGTH_BITS-1:0]      indel_len, indel_len_next;
  logic [LENGTH_BITS-1:0]      skip_rem, skip_rem_next;
  logic [LENGTH_BITS-1:0]      skip_dec, len_less_one;
  logic [3:0][COUNT_BITS-1:0]  counts;
  logic                        sat;

  logic                        is_digit;
  logic [3:0]                  digit_val;
  logic [LENGTH_BITS+3:0]      acc;
  logic [LENGTH_BITS-1:0]      acc_sat;
  logic                        sym_hit, rbase_hit;
  logic [1:0]                  sym_slot, rbase_slot;
  logic                        use_plain;
  logic                        bump_en;
  logic [1:0]                  bump_slot;

  // Map a character to a count lane; hit is low for non-base characters.
  function automatic logic [2:0] base_lookup(input logic [7:0] ch);
    logic [2:0] res;
    unique case (ch)
      8'h41, 8'h61: res = {1'b1, SLOT_A};
      8'h43, 8'h63: res = {1'b1, SLOT_C};
      8'h47, 8'h67: res = {1'b1, SLOT_G};
      8'h54, 8'h74: res = {1'b1, SLOT_T};
      default:      res = 3'b000;
    endcase
    return res;
  endfunction

  assign {sym_hit, sym_slot}     = base_lookup(sym);
  assign {rbase_hit, rbase_slot} = base_lookup(rbase);

  assign is_digit  = (sym >= CH_ZERO) && (sym <= CH_NINE);
  assign digit_val = sym[3:0];

  // Length times ten plus digit, saturating at the all-ones length.
  assign acc = ({4'b0, indel_len} << 3) + ({4'b0, indel_len} << 1)
             + {{LENGTH_BITS{1'b0}}, digit_val};
  assign acc_sat = (acc[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1 : acc[LENGTH_BITS-1:0];

  assign skip_dec     = (skip_rem != '0) ? skip_rem - 1'b1 : skip_rem;
  assign len_less_one = indel_len - 1'b1;

  always_comb begin
    mode_next      = mode;
    indel_len_next = indel_len;
    skip_rem_next  = skip_rem;
    use_plain      = 1'b0;
    bump_en        = 1'b0;
    bump_slot      = SLOT_A;

    unique case (mode)
      MODE_NORMAL: begin
        use_plain = 1'b1;
      end
      MODE_SKIP: begin
        skip_rem_next = skip_dec;
        if (skip_dec == '0) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_SIGN: begin
        if (is_digit) begin
          indel_len_next = LENGTH_BITS'(digit_val);
          mode_next      = MODE_DIGITS;
        end else begin
          mode_next = MODE_NORMAL;
          use_plain = 1'b1;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          indel_len_next = acc_sat;
        end else if (indel_len == '0) begin
          mode_next = MODE_NORMAL;
          use_plain = 1'b1;
        end else begin
          // The terminating character is the first one skipped.
          skip_rem_next  = len_less_one;
          indel_len_next = '0;
          mode_next      = (len_less_one != '0) ? MODE_SKIP : MODE_NORMAL;
        end
      end
    endcase

    if (use_plain) begin
      priority if (sym_hit) begin
        bump_en   = 1'b1;
        bump_slot = sym_slot;
      end else if (sym == CH_CARET) begin
        skip_rem_next = LENGTH_BITS'(1);
        mode_next     = MODE_SKIP;
      end else if ((sym == CH_PLUS) || (sym == CH_MINUS)) begin
        mode_next = MODE_SIGN;
      end else if ((sym == CH_DOT) || (sym == CH_COMMA)) begin
        bump_en   = rbase_hit;
        bump_slot = rbase_slot;
      end else begin
        // Any other character is ignored.
        bump_en = 1'b0;
      end
    end
  end

  // Saturating increment, one lane per base.
  always_comb begin
    done_sat = sat;
    for (int k = 0; k < 4; k++) begin
      done_counts[k] = counts[k];
      if (bump_en && (bump_slot == 2'(k))) begin
        if (counts[k] == '1) begin
          done_sat = 1'b1;
        end else begin
          done_counts[k] = counts[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      indel_len <= '0;
      skip_rem  <= '0;
      counts    <= '0;
      sat       <= 1'b0;
    end else if (step) begin
      if (last) begin
        mode      <= MODE_NORMAL;
        indel_len <= '0;
        skip_rem  <= '0;
        counts    <= '0;
        sat       <= 1'b0;
      end else begin
        mode      <= mode_next;
        indel_len <= indel_len_next;
        skip_rem  <= skip_rem_next;
        counts    <= done_counts;
        sat       <= done_sat;
      end
    end
  end

endmodule

FILE: hw/rtl/pbc_result.sv
// Result register of the pileup base counter, with the coverage sum taken
// after the register. Depends on pbc_pkg for the result port width and lane indices.
module pbc_result
  import pbc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [3:0][COUNT_BITS-1:0] counts_in,
  input  logic                       sat_in,
  output logic                       can_load,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OUT_BITS-1:0]        count_a,
  output logic [OUT_BITS-1:0]        count_c,
  output logic [OUT_BITS-1:0]        count_g,
  output logic [OUT_BITS-1:0]        count_t,
  output logic [OUT_BITS-1:0]        coverage,
  output logic                       overflow
);

  logic [3:0][COUNT_BITS-1:0]      counts;
  logic                            sat;
  logic [COUNT_BITS+1:0]           sum;
  logic [COUNT_BITS-1:0]           sum_sat;
  logic [3:0][COUNT_BITS+OUT_BITS-1:0] cnt_ext;
  logic [COUNT_BITS+OUT_BITS-1:0]  cov_ext;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      counts <= counts_in;
      sat    <= sat_in;
    end
  end

  assign sum = {2'b00, counts[0]} + {2'b00, counts[1]}
             + {2'b00, counts[2]} + {2'b00, counts[3]};
  assign sum_sat  = (sum[COUNT_BITS+1:COUNT_BITS] != 2'b00) ? '1 : sum[COUNT_BITS-1:0];
  assign overflow = sat || (sum[COUNT_BITS+1:COUNT_BITS] != 2'b00);

  // Each value is presented in its low result-port bits.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_ext[k] = {{OUT_BITS{1'b0}}, counts[k]};
    end
  end
  assign cov_ext  = {{OUT_BITS{1'b0}}, sum_sat};

  assign count_a  = cnt_ext[SLOT_A][OUT_BITS-1:0];
  assign count_c  = cnt_ext[SLOT_C][OUT_BITS-1:0];
  assign count_g  = cnt_ext[SLOT_G][OUT_BITS-1:0];
  assign count_t  = cnt_ext[SLOT_T][OUT_BITS-1:0];
  assign coverage = cov_ext[OUT_BITS-1:0];

endmodule

FILE: hw/rtl/pbc_checker.sv
// Port-level checks for the pileup base counter, bound to the top level.
// Depends on pbc_pkg and pileup_base_count_parser.
module pbc_checker
  import pbc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] count_a,
  input logic [OUT_BITS-1:0] count_c,
  input logic [OUT_BITS-1:0] count_g,
  input logic [OUT_BITS-1:0] count_t,
  input logic [OUT_BITS-1:0] coverage,
  input logic                overflow
);

  logic [OUT_BITS+1:0] port_sum;

  assign port_sum = {2'b00, count_a} + {2'b00, count_c}
                  + {2'b00, count_g} + {2'b00, count_t};

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result stays valid and keeps its overflow flag, its A count and its base sum.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coverage) && $stable(count_a)
                                && $stable(overflow))
    else $error("stalled result changed");

  // Without overflow the coverage is the exact sum of the four counts.
  a_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> port_sum == {2'b00, coverage})
    else $error("coverage differs from count sum");

  // Coverage never falls below any single count.
  a_cov_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coverage >= count_a && coverage >= count_c
                  && coverage >= count_g && coverage >= count_t)
    else $error("coverage below a base count");

endmodule

bind pileup_base_count_parser pbc_checker u_pbc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .count_a   (count_a),
  .count_c   (count_c),
  .count_g   (count_g),
  .count_t   (count_t),
  .coverage  (coverage),
  .overflow  (overflow)
);
